[rtl/stl_pkg.sv]
// Shared types and constants for the script token lexer.
// Token kinds, the token record and the per-byte token group.
// No dependencies.
`timescale 1ns / 1ps

package stl_pkg;

    // Token kinds as seen on the result port
    typedef enum logic [2:0] {
        K_BANG    = 3'd0,
        K_COMMA   = 3'd1,
        K_OPEN    = 3'd2,
        K_CLOSE   = 3'd3,
        K_QUOTED  = 3'd4,
        K_WORD    = 3'd5,
        K_NUMBER  = 3'd6,
        K_INVALID = 3'd7
    } t_kind;

    // One lexed token
    typedef struct packed {
        t_kind       kind;
        logic [31:0] start_offset;
        logic [7:0]  length;
        logic [63:0] number_value;
        logic        overflow;
    } t_token;

    // Most tokens one input byte can close
    localparam int GRP_TOKENS = 3;
    // Token groups held between the lexer and the result side
    localparam int GRP_DEPTH  = 2;

    // All tokens one byte causes, oldest in slot 0
    typedef struct packed {
        logic [1:0]                  cnt;
        t_token [GRP_TOKENS-1:0]     tok;
    } t_group;

    // Magnitude of the most negative 64-bit value
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

endpackage

[rtl/stl_front.sv]
// Lexer front end: classifies each accepted byte, tracks the open token and
// writes the group of tokens that the byte closes. Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_front import stl_pkg::*; #(
    parameter int MAX_TOKEN   = 128,
    parameter int OFFSET_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output logic       o_grp_valid,
    output t_group     o_grp
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [4:0] NO_DIGIT = 5'h1F;
    localparam logic [7:0] LEN_MAX  = 8'(MAX_TOKEN);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_TEXT   = 6'b000010,
        PH_SIGN   = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_ZEROX  = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    typedef struct packed {
        t_phase                 phase;
        logic [OFFSET_BITS-1:0] start;
        logic [7:0]             len;
        logic                   sat;
        logic                   quote;
        logic [63:0]            acc;
        logic                   sign;
        t_base                  base;
        logic                   vover;
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] pend;
    } t_st;

    // Idle lexer with no open token
    localparam t_st ST_RESET = '{
        phase: PH_IDLE, start: '0, len: 8'd0, sat: 1'b0, quote: 1'b0, acc: 64'd0,
        sign: 1'b0, base: BASE_DEC, vover: 1'b0, kind: K_WORD, pend: '0
    };

    // Result of opening a token: new state and an optional one-byte token
    typedef struct packed {
        t_st    st;
        logic   emit;
        t_token tok;
    } t_beg;

    // Result of a byte inside a text token: up to two tokens
    typedef struct packed {
        t_st        st;
        logic [1:0] cnt;
        t_token     t0;
        t_token     t1;
    } t_txt;

    t_st                    r_st, n_st;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [1:0]             cnt;
    t_token [GRP_TOKENS-1:0] tk;
    t_beg                   beg;
    t_txt                   txt;
    logic [4:0]             dig;
    logic                   dig_ok;

    function automatic logic f_is_sep(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic logic f_is_punct(input logic [7:0] c);
        return c == CH_BANG || c == CH_COMMA || c == CH_OPEN || c == CH_CLOSE;
    endfunction

    function automatic t_kind f_punct_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_BANG:  k = K_BANG;
            CH_COMMA: k = K_COMMA;
            CH_OPEN:  k = K_OPEN;
            default:  k = K_CLOSE;
        endcase
        return k;
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    // Digit value of a hex character, NO_DIGIT otherwise
    function automatic logic [4:0] f_digit(input logic [7:0] c);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF_A) begin
            d = 5'(c - CH_LA) + 5'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = 5'(c - CH_UA) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic f_fits(input logic [4:0] d, input t_base b);
        logic ok;
        case (b)
            BASE_HEX: ok = !d[4];
            BASE_OCT: ok = d < 5'd8;
            default:  ok = d < 5'd10;
        endcase
        return ok;
    endfunction

    function automatic t_st f_grow(input t_st s);
        t_st r;
        r = s;
        if (s.len < LEN_MAX) begin
            r.len = s.len + 8'd1;
        end else begin
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // Shift in one digit; saturate once the magnitude passes 2^63
    function automatic t_st f_acc(input t_st s, input logic [3:0] d);
        t_st         r;
        logic [67:0] wide;
        logic [67:0] sum;
        r = s;
        case (s.base)
            BASE_HEX: wide = {s.acc, 4'b0};
            BASE_OCT: wide = {1'b0, s.acc, 3'b0};
            default:  wide = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0};
        endcase
        sum = wide + 68'(d);
        if (!s.vover) begin
            if (sum > 68'(MAG_LIMIT)) begin
                r.vover = 1'b1;
                r.acc   = MAG_LIMIT;
            end else begin
                r.acc = sum[63:0];
            end
        end
        return r;
    endfunction

    function automatic t_token f_tok_text(input t_st s);
        t_token t;
        t.kind         = s.kind;
        t.start_offset = 32'(s.start);
        t.length       = s.len;
        t.number_value = '0;
        t.overflow     = s.sat;
        return t;
    endfunction

    function automatic t_token f_tok_one(input t_kind k, input logic [OFFSET_BITS-1:0] p);
        t_token t;
        t.kind         = k;
        t.start_offset = 32'(p);
        t.length       = 8'd1;
        t.number_value = '0;
        t.overflow     = 1'b0;
        return t;
    endfunction

    function automatic t_token f_tok_num(input t_st s);
        t_token t;
        logic   ovf;
        ovf = 1'b0;
        if (s.sign) begin
            if (s.vover) begin
                t.number_value = MAG_LIMIT;
                ovf            = 1'b1;
            end else begin
                t.number_value = 64'd0 - s.acc;
            end
        end else begin
            if (s.vover || s.acc >= MAG_LIMIT) begin
                t.number_value = MAG_LIMIT - 64'd1;
                ovf            = 1'b1;
            end else begin
                t.number_value = s.acc;
            end
        end
        t.kind         = K_NUMBER;
        t.start_offset = 32'(s.start);
        t.length       = s.len;
        t.overflow     = ovf || s.sat;
        return t;
    endfunction

    // Open a token at byte c, or emit a one-byte punctuation token
    function automatic t_beg f_begin(input logic [7:0] c, input logic [OFFSET_BITS-1:0] p,
                                     input t_st s);
        t_beg r;
        r.st   = s;
        r.emit = 1'b0;
        r.tok  = f_tok_one(K_BANG, p);
        if (!f_is_sep(c)) begin
            if (f_is_punct(c)) begin
                r.emit = 1'b1;
                r.tok  = f_tok_one(f_punct_kind(c), p);
            end else begin
                r.st.start = p;
                r.st.len   = 8'd1;
                r.st.sat   = 1'b0;
                r.st.quote = 1'b0;
                r.st.acc   = '0;
                r.st.sign  = 1'b0;
                r.st.base  = BASE_DEC;
                r.st.vover = 1'b0;
                if (c == CH_QUOTE) begin
                    r.st.phase = PH_TEXT;
                    r.st.kind  = K_QUOTED;
                    r.st.quote = 1'b1;
                end else if (f_is_letter(c)) begin
                    r.st.phase = PH_TEXT;
                    r.st.kind  = K_WORD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.st.phase = PH_SIGN;
                    r.st.sign  = (c == CH_MINUS);
                end else if (c == CH_ZERO) begin
                    r.st.phase = PH_ZERO;
                end else if (c > CH_ZERO && c <= CH_NINE) begin
                    r.st.phase = PH_DIGITS;
                    r.st.acc   = 64'(c - CH_ZERO);
                end else begin
                    r.st.phase = PH_TEXT;
                    r.st.kind  = K_INVALID;
                end
            end
        end
        return r;
    endfunction

    // One byte inside a word, quoted or invalid token
    function automatic t_txt f_text(input logic [7:0] c, input logic [OFFSET_BITS-1:0] p,
                                    input t_st s);
        t_txt r;
        r.st  = s;
        r.cnt = 2'd0;
        r.t0  = f_tok_text(s);
        r.t1  = f_tok_one(f_punct_kind(c), p);
        if (f_is_sep(c)) begin
            r.cnt      = 2'd1;
            r.st.phase = PH_IDLE;
        end else if (f_is_punct(c)) begin
            r.cnt      = 2'd2;
            r.st.phase = PH_IDLE;
        end else begin
            r.st = f_grow(s);
            if (c == CH_QUOTE) begin
                if (s.quote) begin
                    r.cnt      = 2'd1;
                    r.t0       = f_tok_text(r.st);
                    r.st.phase = PH_IDLE;
                end else begin
                    r.st.quote = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Lex one byte, then close the open token at end of stream
    always_comb begin
        n_st   = r_st;
        n_pos  = r_pos;
        cnt    = 2'd0;
        tk     = '0;
        beg    = '0;
        txt    = '0;
        dig    = f_digit(i_byte);
        dig_ok = f_fits(dig, (r_st.phase == PH_ZERO) ? BASE_OCT : r_st.base);
        if (i_valid) begin
            unique case (r_st.phase)
                PH_TEXT: begin
                    txt   = f_text(i_byte, r_pos, n_st);
                    n_st  = txt.st;
                    tk[0] = txt.t0;
                    tk[1] = txt.t1;
                    cnt   = txt.cnt;
                end
                PH_SIGN: begin
                    if (i_byte == CH_ZERO) begin
                        n_st       = f_grow(n_st);
                        n_st.phase = PH_ZERO;
                    end else if (i_byte > CH_ZERO && i_byte <= CH_NINE) begin
                        n_st       = f_grow(n_st);
                        n_st.acc   = 64'(dig);
                        n_st.phase = PH_DIGITS;
                    end else begin
                        n_st.phase = PH_TEXT;
                        n_st.kind  = K_INVALID;
                        txt        = f_text(i_byte, r_pos, n_st);
                        n_st       = txt.st;
                        tk[0]      = txt.t0;
                        tk[1]      = txt.t1;
                        cnt        = txt.cnt;
                    end
                end
                PH_ZERO, PH_DIGITS: begin
                    if (r_st.phase == PH_ZERO && (i_byte == CH_LX || i_byte == CH_UX)) begin
                        n_st.phase = PH_ZEROX;
                        n_st.pend  = r_pos;
                    end else if (dig_ok) begin
                        n_st = f_grow(n_st);
                        if (r_st.phase == PH_ZERO) begin
                            n_st.base = BASE_OCT;
                        end
                        n_st       = f_acc(n_st, dig[3:0]);
                        n_st.phase = PH_DIGITS;
                    end else begin
                        tk[0]      = f_tok_num(n_st);
                        cnt        = 2'd1;
                        n_st.phase = PH_IDLE;
                        beg        = f_begin(i_byte, r_pos, n_st);
                        n_st       = beg.st;
                        tk[1]      = beg.tok;
                        if (beg.emit) begin
                            cnt = 2'd2;
                        end
                    end
                end
                PH_ZEROX: begin
                    if (!dig[4]) begin
                        n_st       = f_grow(f_grow(n_st));
                        n_st.base  = BASE_HEX;
                        n_st       = f_acc(n_st, dig[3:0]);
                        n_st.phase = PH_DIGITS;
                    end else begin
                        // number ends at the zero; the x restarts as a word
                        tk[0]      = f_tok_num(n_st);
                        n_st.phase = PH_IDLE;
                        beg        = f_begin(CH_LX, r_st.pend, n_st);
                        txt        = f_text(i_byte, r_pos, beg.st);
                        n_st       = txt.st;
                        tk[1]      = txt.t0;
                        tk[2]      = txt.t1;
                        cnt        = 2'd1 + txt.cnt;
                    end
                end
                default: begin
                    beg   = f_begin(i_byte, r_pos, n_st);
                    n_st  = beg.st;
                    tk[0] = beg.tok;
                    if (beg.emit) begin
                        cnt = 2'd1;
                    end
                end
            endcase

            n_pos = r_pos + OFFSET_BITS'(1);

            // close the pending token at end of stream
            if (i_eos) begin
                unique case (n_st.phase)
                    PH_TEXT: begin
                        tk[cnt] = f_tok_text(n_st);
                        cnt     = cnt + 2'd1;
                    end
                    PH_SIGN: begin
                        n_st.kind = K_INVALID;
                        tk[cnt]   = f_tok_text(n_st);
                        cnt       = cnt + 2'd1;
                    end
                    PH_ZERO, PH_DIGITS: begin
                        tk[cnt] = f_tok_num(n_st);
                        cnt     = cnt + 2'd1;
                    end
                    PH_ZEROX: begin
                        tk[0] = f_tok_num(n_st);
                        tk[1] = f_tok_one(K_WORD, n_st.pend);
                        cnt   = 2'd2;
                    end
                    default: begin
                    end
                endcase
                n_st.phase = PH_IDLE;
                n_pos      = '0;
            end
        end
    end

    assign o_grp_valid = i_valid && (cnt != 2'd0);
    assign o_grp.cnt   = cnt;
    assign o_grp.tok   = tk;

    // Hold lexer state and stream offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_RESET;
            r_pos <= '0;
        end else begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

endmodule

[rtl/stl_grp_queue.sv]
// Short queue of token groups between the lexer and the result side.
// Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_grp_queue import stl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_head
);

    localparam int PTR_W = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
    localparam int CNT_W = $clog2(GRP_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(GRP_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(GRP_DEPTH);

    t_group           r_mem [GRP_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // Store a written group
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group written into a full queue");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_data.cnt != 2'd0))
        else $error("empty token group written");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

[rtl/stl_back.sv]
// Result side: walks the tokens of the head group one request at a time
// and marks the last token of each group. Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_back import stl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_group i_head,
    input  logic   i_head_valid,
    input  logic   i_pop,
    output logic   o_empty,
    output t_token o_tok,
    output logic   o_last,
    output logic   o_deq
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;

    assign o_empty = !i_head_valid;
    assign o_tok   = i_head.tok[r_idx];
    assign o_last  = (r_idx == i_head.cnt - 2'd1);
    assign o_deq   = i_pop && i_head_valid && o_last;

    // Step through the group; restart when it is released
    always_comb begin
        n_idx = r_idx;
        if (i_pop && i_head_valid) begin
            n_idx = o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx < i_head.cnt))
        else $error("token index past end of group");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == 2'd0))
        else $error("token index left set with no group waiting");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && i_head_valid && !o_last) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("token index did not advance on request");
`endif

endmodule

[rtl/script_token_lexer.sv]
// Script token lexer: stream of bytes in, stream of tokens out.
// Depends on stl_pkg, stl_front, stl_grp_queue and stl_back.
//
// Usage:
//   Input is a queue port: drive i_byte_in / i_end_of_stream with push; a
//   byte is taken on a clock edge with push high and full low. Set
//   i_end_of_stream on the last byte to close the open token; offsets
//   restart at zero for the next stream.
//   Output is a queue port: while empty is low the oldest token sits on the
//   o_ ports; it is taken on an edge with pop high. o_last_of_run marks the
//   last token caused by one input byte.
// Path: the tokens a byte closes are registered in the group queue (one
//   register stage) and reach the o_ ports once older tokens are popped.
// Throughput: one byte per cycle on input while full is low. Each byte
//   closes zero to three tokens, delivered one per cycle while pop is high;
//   the two-entry group queue lets the lexer keep taking bytes while tokens
//   wait, and full rises only once two groups are waiting.
// Reset: synchronous, active low; lexer idle, offset zero, queue empty.
// Stall: when pop stays low tokens hold on the outputs, the queue fills and
//   full holds off further bytes; no token is dropped.
`timescale 1ns / 1ps

module script_token_lexer import stl_pkg::*; #(
    parameter int MAX_TOKEN   = 128,
    parameter int OFFSET_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_byte_in,
    input  logic               i_end_of_stream,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_start_offset,
    output logic [7:0]         o_length,
    output logic signed [63:0] o_number_value,
    output logic               o_overflow,
    output logic               o_last_of_run
);

    logic   accept;
    logic   grp_valid;
    t_group grp;
    t_group head;
    logic   q_empty;
    logic   deq;
    t_token tok;

    assign accept = push && !full;

    // Lex bytes into token groups
    stl_front #(
        .MAX_TOKEN   (MAX_TOKEN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_byte_in),
        .i_eos       (i_end_of_stream),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    // Buffer groups between the two sides
    stl_grp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grp_valid),
        .i_data  (grp),
        .i_pop   (deq),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Deliver tokens one request at a time
    stl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!q_empty),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_tok        (tok),
        .o_last       (o_last_of_run),
        .o_deq        (deq)
    );

    assign o_kind         = tok.kind;
    assign o_start_offset = tok.start_offset;
    assign o_length       = tok.length;
    assign o_number_value = signed'(tok.number_value);
    assign o_overflow     = tok.overflow;

endmodule

[sim/tb_script_token_lexer.sv]
// Testbench for script_token_lexer: random and directed byte streams in, tokens checked out.
// A scoreboard class predicts every token from the accepted bytes and checks them in order.
// Depends on stl_pkg and script_token_lexer.
`timescale 1ns / 1ps

module tb_script_token_lexer;
    import stl_pkg::*;

    localparam int TOK_MAX        = 128;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_COUNT     = 480;
    localparam int IDLE_PCT       = 38;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_AFTER     = 40;

    // Characters with a role of their own
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam string SEPS       = " \t\r\n";
    localparam string PUNCTS     = "!,()";
    localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DEC_DIGITS = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string ODD_BYTES  = "#$%&*./:;<=>?@[]^_`{|}~";

    typedef enum logic [2:0] {
        LX_IDLE, LX_TEXT, LX_SIGN, LX_ZERO, LX_ZEROX, LX_DIGITS
    } t_lex_phase;

    typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} t_radix;

    typedef struct {
        t_token tok;
        logic   last;
    } t_expect_tok;

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } t_stim;

    // Token predictor and in-order checker
    class token_scoreboard;
        t_expect_tok expected[$];
        t_token      step_toks[$];
        int          errors;

        t_lex_phase  phase;
        t_radix      radix;
        t_kind       tok_kind;
        logic [31:0] pos;
        logic [31:0] tok_start;
        logic [31:0] pend_pos;
        logic [7:0]  pend_byte;
        logic [63:0] acc;
        int          tok_len;
        bit          quote_open;
        bit          neg;
        bit          sat;
        bit          val_over;

        function new();
            errors = 0;
            phase = LX_IDLE;
            radix = RADIX_DEC;
            tok_kind = K_WORD;
            pos = '0;
            tok_start = '0;
            pend_pos = '0;
            pend_byte = '0;
            acc = '0;
            tok_len = 0;
            quote_open = 0;
            neg = 0;
            sat = 0;
            val_over = 0;
        endfunction

        function bit is_sep(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function bit is_punct(logic [7:0] c, output t_kind k);
            k = K_BANG;
            case (c)
                CH_BANG:  k = K_BANG;
                CH_COMMA: k = K_COMMA;
                CH_OPEN:  k = K_OPEN;
                CH_CLOSE: k = K_CLOSE;
                default:  return 0;
            endcase
            return 1;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function int digit_of(logic [7:0] c, t_radix r);
            int d;
            d = -1;
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            if (r == RADIX_DEC && d > 9) d = -1;
            if (r == RADIX_OCT && d > 7) d = -1;
            return d;
        endfunction

        // Hold at most one group of tokens per byte
        function void emit(t_kind k, logic [31:0] s, int len, logic [63:0] v, bit ovf);
            t_token t;
            if (step_toks.size() >= GRP_TOKENS) return;
            t.kind = k;
            t.start_offset = s;
            t.length = len[7:0];
            t.number_value = v;
            t.overflow = ovf;
            step_toks.push_back(t);
        endfunction

        function void grow();
            if (tok_len < TOK_MAX) tok_len++;
            else sat = 1;
        endfunction

        // Shift in one digit, pin the magnitude at 2^63 on overflow
        function void accumulate(int d);
            logic [63:0] b;
            b = (radix == RADIX_HEX) ? 64'd16 : ((radix == RADIX_OCT) ? 64'd8 : 64'd10);
            if (val_over) return;
            if (acc > (MAG_LIMIT - 64'(d)) / b) begin
                val_over = 1;
                acc = MAG_LIMIT;
            end else begin
                acc = acc * b + 64'(d);
            end
        endfunction

        function void emit_number();
            logic [63:0] v;
            bit ovf;
            ovf = 0;
            if (neg) begin
                if (val_over) begin
                    v = MAG_LIMIT;
                    ovf = 1;
                end else begin
                    v = 64'd0 - acc;
                end
            end else if (val_over || acc >= MAG_LIMIT) begin
                v = MAG_LIMIT - 64'd1;
                ovf = 1;
            end else begin
                v = acc;
            end
            emit(K_NUMBER, tok_start, tok_len, v, ovf || sat);
            phase = LX_IDLE;
        endfunction

        function void emit_text();
            emit(tok_kind, tok_start, tok_len, 64'd0, sat);
            phase = LX_IDLE;
        endfunction

        // Open a token on its first byte
        function void begin_token(logic [7:0] c, logic [31:0] p);
            t_kind pk;
            if (is_sep(c)) return;
            if (is_punct(c, pk)) begin
                emit(pk, p, 1, 64'd0, 0);
                return;
            end
            tok_start = p;
            tok_len = 1;
            sat = 0;
            quote_open = 0;
            acc = '0;
            neg = 0;
            radix = RADIX_DEC;
            val_over = 0;
            if (c == CH_QUOTE) begin
                phase = LX_TEXT;
                tok_kind = K_QUOTED;
                quote_open = 1;
            end else if (is_letter(c)) begin
                phase = LX_TEXT;
                tok_kind = K_WORD;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                phase = LX_SIGN;
                neg = (c == CH_MINUS);
            end else if (c == "0") begin
                phase = LX_ZERO;
            end else if (c >= "1" && c <= "9") begin
                phase = LX_DIGITS;
                acc = c - "0";
            end else begin
                phase = LX_TEXT;
                tok_kind = K_INVALID;
            end
        endfunction

        function void text_byte(logic [7:0] c, logic [31:0] p);
            t_kind pk;
            if (is_sep(c)) begin
                emit_text();
                return;
            end
            if (is_punct(c, pk)) begin
                emit_text();
                begin_token(c, p);
                return;
            end
            grow();
            if (c == CH_QUOTE) begin
                if (quote_open) emit_text();
                else quote_open = 1;
            end
        endfunction

        function void feed(logic [7:0] c, logic [31:0] p);
            int d;
            case (phase)
                LX_TEXT: begin
                    text_byte(c, p);
                end
                LX_SIGN: begin
                    if (c == "0") begin
                        grow();
                        phase = LX_ZERO;
                    end else if (c >= "1" && c <= "9") begin
                        grow();
                        acc = c - "0";
                        phase = LX_DIGITS;
                    end else begin
                        phase = LX_TEXT;
                        tok_kind = K_INVALID;
                        text_byte(c, p);
                    end
                end
                LX_ZERO: begin
                    d = digit_of(c, RADIX_OCT);
                    if (c == "x" || c == "X") begin
                        pend_byte = c;
                        pend_pos = p;
                        phase = LX_ZEROX;
                    end else if (d >= 0) begin
                        grow();
                        radix = RADIX_OCT;
                        accumulate(d);
                        phase = LX_DIGITS;
                    end else begin
                        emit_number();
                        begin_token(c, p);
                    end
                end
                LX_ZEROX: begin
                    // No hex digit: the zero stands alone and the x opens a word
                    d = digit_of(c, RADIX_HEX);
                    if (d >= 0) begin
                        grow();
                        grow();
                        radix = RADIX_HEX;
                        accumulate(d);
                        phase = LX_DIGITS;
                    end else begin
                        emit_number();
                        begin_token(pend_byte, pend_pos);
                        feed(c, p);
                    end
                end
                LX_DIGITS: begin
                    d = digit_of(c, radix);
                    if (d >= 0) begin
                        grow();
                        accumulate(d);
                    end else begin
                        emit_number();
                        begin_token(c, p);
                    end
                end
                default: begin
                    phase = LX_IDLE;
                    begin_token(c, p);
                end
            endcase
        endfunction

        // Close whatever is open at the end of a stream
        function void flush();
            case (phase)
                LX_TEXT: begin
                    emit_text();
                end
                LX_SIGN: begin
                    tok_kind = K_INVALID;
                    emit_text();
                end
                LX_ZERO, LX_DIGITS: begin
                    emit_number();
                end
                LX_ZEROX: begin
                    emit_number();
                    emit(K_WORD, pend_pos, 1, 64'd0, 0);
                end
                default: ;
            endcase
            phase = LX_IDLE;
        endfunction

        // Note one accepted request and queue the tokens it closes
        function void note_byte(logic [7:0] c, logic eos);
            logic [31:0] p;
            t_expect_tok e;
            p = pos;
            step_toks.delete();
            feed(c, p);
            pos = p + 32'd1;
            if (eos) begin
                flush();
                pos = '0;
            end
            foreach (step_toks[i]) begin
                e.tok = step_toks[i];
                e.last = (i == step_toks.size() - 1);
                expected.push_back(e);
            end
        endfunction

        task report(string msg);
            if (errors < 30) $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        // Compare one popped token with the oldest prediction
        task check_token(logic [2:0] k, logic [31:0] s, logic [7:0] len, logic [63:0] v,
                         logic ovf, logic last);
            t_expect_tok e;
            if (expected.size() == 0) begin
                report($sformatf("unexpected token: kind %0d offset %0d", k, s));
                return;
            end
            e = expected.pop_front();
            if (k !== e.tok.kind)
                report($sformatf("kind: got %0d, want %0d (offset %0d)",
                                 k, e.tok.kind, e.tok.start_offset));
            if (s !== e.tok.start_offset)
                report($sformatf("start_offset: got %0d, want %0d", s, e.tok.start_offset));
            if (len !== e.tok.length)
                report($sformatf("length: got %0d, want %0d (offset %0d)",
                                 len, e.tok.length, e.tok.start_offset));
            if (v !== e.tok.number_value)
                report($sformatf("number_value: got %0d, want %0d (offset %0d)",
                                 $signed(v), $signed(e.tok.number_value),
                                 e.tok.start_offset));
            if (ovf !== e.tok.overflow)
                report($sformatf("overflow: got %0b, want %0b (offset %0d)",
                                 ovf, e.tok.overflow, e.tok.start_offset));
            if (last !== e.last)
                report($sformatf("last_of_run: got %0b, want %0b (offset %0d)",
                                 last, e.last, e.tok.start_offset));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_byte_in = 8'h00;
    logic               i_end_of_stream = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_kind;
    logic [31:0]        o_start_offset;
    logic [7:0]         o_length;
    logic signed [63:0] o_number_value;
    logic               o_overflow;
    logic               o_last_of_run;

    token_scoreboard sb = new();
    t_stim           stim_q[$];
    bit              steady = 0;

    script_token_lexer #(
        .MAX_TOKEN  (TOK_MAX),
        .OFFSET_BITS(32)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_byte_in      (i_byte_in),
        .i_end_of_stream(i_end_of_stream),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_start_offset (o_start_offset),
        .o_length       (o_length),
        .o_number_value (o_number_value),
        .o_overflow     (o_overflow),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void put(logic [7:0] b, logic e = 1'b0);
        t_stim s;
        s.b = b;
        s.eos = e;
        stim_q.push_back(s);
    endfunction

    // Queue a string, end of stream on its last byte when asked
    function automatic void put_text(string s, logic e = 1'b0);
        for (int i = 0; i < s.len(); i++) put(s[i], e && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Runs near and past the length limit, numbers past the value limit among them
    function automatic void add_long_token(int pick_kind);
        int n;
        n = $urandom_range(125, 140);
        case (pick_kind)
            0: begin
                put(pick(LETTERS));
                repeat (n - 1) put(pick({LETTERS, DEC_DIGITS}));
            end
            1: begin
                put(pick("123456789"));
                repeat (n - 1) put(pick(DEC_DIGITS));
            end
            default: begin
                put(CH_QUOTE);
                repeat (n - 2) put(pick({LETTERS, ODD_BYTES}));
                put(CH_QUOTE);
            end
        endcase
    endfunction

    // Mostly well-formed tokens with random content, some noise
    function automatic void add_random_token();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = $urandom_range(1, 3);
            repeat (n) put(pick(SEPS));
        end else if (r < 20) begin
            put(pick(PUNCTS));
        end else if (r < 32) begin
            put(pick(LETTERS));
            n = $urandom_range(0, 8);
            repeat (n) put(pick({LETTERS, DEC_DIGITS}));
        end else if (r < 42) begin
            put(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) put(pick({LETTERS, DEC_DIGITS, "+-#x"}));
            if ($urandom_range(0, 3) != 0) put(CH_QUOTE);
        end else if (r < 57) begin
            if ($urandom_range(0, 2) == 0) put(pick("+-"));
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 6);
            put(pick("123456789"));
            repeat (n - 1) put(pick(DEC_DIGITS));
        end else if (r < 65) begin
            if ($urandom_range(0, 2) == 0) put(pick("+-"));
            put("0");
            put(pick("xX"));
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
            repeat (n) put(pick(HEX_DIGITS));
        end else if (r < 71) begin
            if ($urandom_range(0, 2) == 0) put(pick("+-"));
            put("0");
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 23) : $urandom_range(0, 4);
            repeat (n) put(pick("01234567"));
            if ($urandom_range(0, 2) == 0) put(pick("89"));
        end else if (r < 76) begin
            put("0");
            put(pick("xX"));
            put(pick("gGzZ!,() \t\"#+"));
        end else if (r < 81) begin
            if ($urandom_range(0, 1) == 0) put(pick("+-"));
            else put(pick(ODD_BYTES));
            n = $urandom_range(0, 3);
            repeat (n) put(pick({LETTERS, ODD_BYTES}));
        end else if (r < 93) begin
            n = $urandom_range(1, 3);
            repeat (n) put(8'($urandom_range(0, 255)));
        end else if (r < 94) begin
            add_long_token($urandom_range(0, 2));
        end else begin
            // Quote met in the middle of a word
            put(pick(LETTERS));
            put(CH_QUOTE);
            n = $urandom_range(0, 3);
            repeat (n) put(pick(LETTERS));
            if ($urandom_range(0, 1) == 0) put(CH_QUOTE);
        end
        if ($urandom_range(0, 1) == 0) put(pick(SEPS));
        if ($urandom_range(0, 29) == 0) stim_q[$].eos = 1'b1;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_byte(logic [7:0] b, logic e);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        i_byte_in <= b;
        i_end_of_stream <= e;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(b, e);
    endtask

    // Stimulus: directed strings, then random token streams
    initial begin
        put_text("! , ( ) ");
        put_text("\"a b\" \"ab\"cd word\"x\"y ");
        put_text("9223372036854775807 9223372036854775808 ");
        put_text("-9223372036854775808 -9223372036854775809 +0 ");
        put_text("0x7fffFFFFffffffff,0X8000000000000000 0xG 0x(");
        put_text("017 08 0779 - + -x ");
        put_text("#q");
        put(8'hFF);
        put(8'h00);
        put_text(" 12ab\t\r\n");
        put_text("abc", 1'b1);
        put_text("\"open", 1'b1);
        put_text("-", 1'b1);
        put_text("0x", 1'b1);
        put_text("7", 1'b1);
        add_long_token(1);
        put(CH_COMMA);
        while (stim_q.size() < ITEM_COUNT) add_random_token();
        stim_q[$].eos = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_q[k]) begin
            steady = (k >= 200 && k < 300);
            send_byte(stim_q[k].b, stim_q[k].eos);
        end
        push <= 1'b0;
        steady = 0;

        // Drain, then give stray tokens a chance to show up
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_script_token_lexer: PASS");
        end else begin
            $display("tb_script_token_lexer: FAIL");
        end
        $finish;
    end

    // Result side: check each popped token, pop at random, hold off once
    initial begin
        int taken;
        int hold_left;
        bit held;
        taken = 0;
        hold_left = 0;
        held = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_token(o_kind, o_start_offset, o_length, o_number_value,
                               o_overflow, o_last_of_run);
                taken++;
            end
            if (!held && taken >= HOLD_AFTER) begin
                held = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (steady) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_script_token_lexer: FAIL");
                $finish;
            end
        end
    end

endmodule
